### design/heartbeat_liveness_table_macros.svh
// Assertion macros shared by the liveness table design
`ifndef HEARTBEAT_LIVENESS_TABLE_MACROS_SVH
`define HEARTBEAT_LIVENESS_TABLE_MACROS_SVH

// same-cycle implication
`define HLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hlt_pkg.sv
// Types and constants of the heartbeat liveness table
package hlt_pkg;

  localparam int MODE_W     = 2;
  localparam int KEY_W      = 64;
  localparam int CVAL_W     = 7;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 5;
  localparam int COUNTER_W  = 16;
  localparam int INTERVAL_W = 8;
  localparam int STEP_W     = 8;
  localparam int MULT_W     = 4;
  localparam int LIMIT_W    = INTERVAL_W + MULT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [COUNTER_W-1:0] COUNTER_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MULTIPLE = 2'd2;

  localparam logic [STEP_W-1:0]     RST_TICK_STEP        = 8'd5;
  localparam logic [INTERVAL_W-1:0] RST_DEFAULT_INTERVAL = 8'd30;
  localparam logic [MULT_W-1:0]     RST_TIMEOUT_MULTIPLE = 4'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_ADD     = 2'd2,
    MODE_DELETE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_TIMED_OUT = 3'd4,
    ST_TICK_DONE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNTER_W-1:0]  counter;
    logic [INTERVAL_W-1:0] interval;
    logic                  online;
  } entry_t;

  typedef struct packed {
    logic [STEP_W-1:0]     tick_step;
    logic [INTERVAL_W-1:0] default_interval;
    logic [MULT_W-1:0]     timeout_multiple;
  } cfg_t;

  typedef struct packed {
    logic                 key_hit;
    logic [COUNTER_W-1:0] counter;
    logic                 expired;
  } alu_res_t;

endpackage

### design/hlt_ram.sv
// Generic single-write, single-read RAM with registered read data
module hlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/hlt_alu.sv
// Shared slot unit: key compare, saturating counter advance and timeout compare
module hlt_alu (
  input  hlt_pkg::entry_t               entry,
  input  hlt_pkg::cfg_t                 cfg,
  input  logic [hlt_pkg::KEY_W-1:0]     key,
  output hlt_pkg::alu_res_t             res
);
  import hlt_pkg::*;

  logic [COUNTER_W:0]   sum;
  logic [COUNTER_W-1:0] sat;
  logic [LIMIT_W-1:0]   limit;

  always_comb begin
    sum   = {1'b0, entry.counter} + (COUNTER_W + 1)'(cfg.tick_step);
    sat   = sum[COUNTER_W] ? COUNTER_MAX : sum[COUNTER_W-1:0];
    limit = LIMIT_W'(cfg.timeout_multiple) * LIMIT_W'(entry.interval);
    res.key_hit = (entry.key == key);
    res.counter = sat;
    res.expired = (sat > COUNTER_W'(limit));
  end

endmodule

### design/hlt_ctrl.sv
// Sequencer: slot walk, valid bits, table updates and result register
module hlt_ctrl #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  hlt_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hlt_pkg::MODE_W-1:0]             mode,
  input  logic [hlt_pkg::KEY_W-1:0]              device_key,
  input  logic [hlt_pkg::CVAL_W-1:0]             counter_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [hlt_pkg::STATUS_W-1:0]           status,
  output logic [hlt_pkg::KEY_W-1:0]              entry_key,
  output logic [hlt_pkg::SLOT_W-1:0]             entry_slot,
  output logic                                   now_online,
  output logic                                   last,
  output logic                                   ram_we,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
  output hlt_pkg::entry_t                        ram_wdata,
  output logic                                   ram_re,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
  input  hlt_pkg::entry_t                        ram_rdata,
  output logic [hlt_pkg::KEY_W-1:0]              lookup_key,
  input  hlt_pkg::alu_res_t                      alu_res
);
  import hlt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_DEPTH);

  state_t                 state, state_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic                   hit, hit_next;
  logic                   free_found, free_found_next;
  logic [IDX_W-1:0]       free_idx, free_idx_next;
  logic [TABLE_DEPTH-1:0] valid, valid_next;
  mode_t                  mode_q, mode_q_next;
  logic [KEY_W-1:0]       key_q, key_q_next;
  logic [CVAL_W-1:0]      cval_q, cval_q_next;
  logic                   out_valid_next;
  status_t                out_status, out_status_next;
  logic [KEY_W-1:0]       out_key, out_key_next;
  logic [SLOT_W-1:0]      out_slot, out_slot_next;
  logic                   out_online, out_online_next;
  logic                   out_last, out_last_next;
  logic                   emit;
  logic                   can_emit;
  logic [IDX_W-1:0]       slot;

  assign in_stall   = (state != S_IDLE);
  assign status     = out_status;
  assign entry_key  = out_key;
  assign entry_slot = out_slot;
  assign now_online = out_online;
  assign last       = out_last;
  assign lookup_key = key_q;
  assign slot       = idx[IDX_W-1:0];
  assign can_emit   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      hit        <= hit_next;
      free_found <= free_found_next;
      valid      <= valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    free_idx   <= free_idx_next;
    mode_q     <= mode_q_next;
    key_q      <= key_q_next;
    cval_q     <= cval_q_next;
    out_status <= out_status_next;
    out_key    <= out_key_next;
    out_slot   <= out_slot_next;
    out_online <= out_online_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    hit_next        = hit;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    valid_next      = valid;
    mode_q_next     = mode_q;
    key_q_next      = key_q;
    cval_q_next     = cval_q;
    out_status_next = out_status;
    out_key_next    = out_key;
    out_slot_next   = out_slot;
    out_online_next = out_online;
    out_last_next   = out_last;
    emit            = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = slot;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = slot;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_q_next     = mode_t'(mode);
          key_q_next      = device_key;
          cval_q_next     = counter_value;
          idx_next        = '0;
          hit_next        = 1'b0;
          free_found_next = 1'b0;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_FINISH;
        end else if (valid[slot]) begin
          ram_re     = 1'b1;
          state_next = S_CHECK;
        end else begin
          if (!free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = slot;
          end
          idx_next = idx + 1'b1;
        end
      end
      S_CHECK: begin
        if (mode_q == MODE_TICK) begin
          if (ram_rdata.online) begin
            ram_we    = 1'b1;
            ram_wdata = '{key: ram_rdata.key, counter: alu_res.counter,
                          interval: ram_rdata.interval, online: !alu_res.expired};
          end
          if (ram_rdata.online && alu_res.expired) begin
            state_next = S_EMIT;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SCAN;
          end
        end else if (alu_res.key_hit) begin
          hit_next   = 1'b1;
          state_next = S_FINISH;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit            = 1'b1;
          out_status_next = ST_TIMED_OUT;
          out_key_next    = ram_rdata.key;
          out_slot_next   = SLOT_W'(idx);
          out_online_next = 1'b0;
          out_last_next   = 1'b0;
          idx_next        = idx + 1'b1;
          state_next      = S_SCAN;
        end
      end
      S_FINISH: begin
        if (can_emit) begin
          emit            = 1'b1;
          state_next      = S_IDLE;
          out_key_next    = key_q;
          out_slot_next   = '0;
          out_online_next = 1'b0;
          out_last_next   = 1'b1;
          unique case (mode_q)
            MODE_TICK: begin
              out_status_next = ST_TICK_DONE;
              out_key_next    = '0;
            end
            MODE_REFRESH: begin
              if (hit) begin
                ram_we          = 1'b1;
                ram_wdata       = '{key: ram_rdata.key, counter: COUNTER_W'(cval_q),
                                    interval: ram_rdata.interval, online: 1'b1};
                out_status_next = ST_OK;
                out_slot_next   = SLOT_W'(idx);
                out_online_next = 1'b1;
              end else begin
                out_status_next = ST_NOT_FOUND;
              end
            end
            MODE_ADD: begin
              if (hit) begin
                out_status_next = ST_PRESENT;
                out_slot_next   = SLOT_W'(idx);
                out_online_next = ram_rdata.online;
              end else if (free_found) begin
                ram_we                  = 1'b1;
                ram_waddr               = free_idx;
                ram_wdata               = '{key: key_q, counter: '0,
                                            interval: cfg.default_interval, online: 1'b1};
                valid_next[free_idx]    = 1'b1;
                out_status_next         = ST_OK;
                out_slot_next           = SLOT_W'(free_idx);
                out_online_next         = 1'b1;
              end else begin
                out_status_next = ST_FULL;
              end
            end
            MODE_DELETE: begin
              if (hit) begin
                valid_next[slot] = 1'b0;
                out_status_next  = ST_OK;
                out_slot_next    = SLOT_W'(idx);
              end else begin
                out_status_next = ST_NOT_FOUND;
              end
            end
            default: begin
              out_status_next = ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = emit || (out_valid && out_stall);
  end

endmodule

### design/heartbeat_liveness_table.sv
// Heartbeat liveness table: one request (tick, refresh, add or delete) at a time.
// A request walks the slots in order through the single read port of the slot RAM;
// an empty slot is skipped in the scan state, and an occupied slot is read there and
// checked in the check state. The walk ends in a finish state. A lookup stops at the
// first matching slot; a tick walks every slot and passes each slot that times out
// through an emit state, which holds while the output stalls. Results leave through
// an output register, so the next request is taken while the final result still
// waits. No clearing pass after reset.

`include "heartbeat_liveness_table_macros.svh"

module heartbeat_liveness_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hlt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hlt_pkg::MODE_W-1:0]         mode,
  input  logic [hlt_pkg::KEY_W-1:0]          device_key,
  input  logic [hlt_pkg::CVAL_W-1:0]         counter_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hlt_pkg::STATUS_W-1:0]       status,
  output logic [hlt_pkg::KEY_W-1:0]          entry_key,
  output logic [hlt_pkg::SLOT_W-1:0]         entry_slot,
  output logic                               now_online,
  output logic                               last
);
  import hlt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t             cfg;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic [KEY_W-1:0] lookup_key;
  alu_res_t         alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_step        <= RST_TICK_STEP;
      cfg.default_interval <= RST_DEFAULT_INTERVAL;
      cfg.timeout_multiple <= RST_TIMEOUT_MULTIPLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICK_STEP:        cfg.tick_step        <= cfg_data;
        CFG_DEFAULT_INTERVAL: cfg.default_interval <= cfg_data;
        CFG_TIMEOUT_MULTIPLE: cfg.timeout_multiple <= cfg_data[MULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hlt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hlt_alu u_alu (
    .entry (ram_rdata),
    .cfg   (cfg),
    .key   (lookup_key),
    .res   (alu_res)
  );

  hlt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .device_key    (device_key),
    .counter_value (counter_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_key     (entry_key),
    .entry_slot    (entry_slot),
    .now_online    (now_online),
    .last          (last),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .lookup_key    (lookup_key),
    .alu_res       (alu_res)
  );

  `HLT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after request")
  `HLT_ASSERT_NOW(a_tick_done_last, out_valid && status == ST_TICK_DONE, last && entry_key == 64'd0, "bad tick_done result")
  `HLT_ASSERT_NOW(a_miss_no_slot, out_valid && (status == ST_NOT_FOUND || status == ST_FULL), entry_slot == 5'd0 && !now_online, "miss result carries slot")

endmodule

### tb/heartbeat_liveness_checker.sv
`timescale 1ns / 100ps
// Checker for the heartbeat liveness table: mirrors the slot table and compares every result
module heartbeat_liveness_checker #(
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [hlt_pkg::MODE_W-1:0]     mode,
  input  logic [hlt_pkg::KEY_W-1:0]      device_key,
  input  logic [hlt_pkg::CVAL_W-1:0]     counter_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [hlt_pkg::STATUS_W-1:0]   status,
  input  logic [hlt_pkg::KEY_W-1:0]      entry_key,
  input  logic [hlt_pkg::SLOT_W-1:0]     entry_slot,
  input  logic                           now_online,
  input  logic                           last,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  import hlt_pkg::*;

  typedef struct {
    status_t           status;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic              online;
    logic              last;
  } liveness_result_t;

  logic                  m_valid    [DEPTH];
  logic [KEY_W-1:0]      m_key      [DEPTH];
  logic [COUNTER_W-1:0]  m_counter  [DEPTH];
  logic [INTERVAL_W-1:0] m_interval [DEPTH];
  logic                  m_online   [DEPTH];

  logic [STEP_W-1:0]     c_step;
  logic [INTERVAL_W-1:0] c_interval;
  logic [MULT_W-1:0]     c_mult;

  liveness_result_t awaited_results[$];

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < DEPTH; i++) begin
      if (m_valid[i] && m_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void push_result(status_t s, logic [KEY_W-1:0] k, int slot,
                                      logic online, logic fin);
    liveness_result_t r;
    r.status = s;
    r.key    = k;
    r.slot   = SLOT_W'(slot);
    r.online = online;
    r.last   = fin;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_request(mode_t m, logic [KEY_W-1:0] k,
                                          logic [CVAL_W-1:0] cv);
    int hit;
    int free_slot;
    logic [COUNTER_W:0] sum;
    logic [LIMIT_W-1:0] limit;
    hit = find_slot(k);
    free_slot = -1;
    case (m)
      MODE_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (m_valid[i] && m_online[i]) begin
            sum = {1'b0, m_counter[i]} + (COUNTER_W + 1)'(c_step);
            if (sum > {1'b0, COUNTER_MAX}) sum = {1'b0, COUNTER_MAX};
            m_counter[i] = sum[COUNTER_W-1:0];
            limit = LIMIT_W'(c_mult) * LIMIT_W'(m_interval[i]);
            if (m_counter[i] > COUNTER_W'(limit)) begin
              m_online[i] = 1'b0;
              push_result(ST_TIMED_OUT, m_key[i], i, 1'b0, 1'b0);
            end
          end
        end
        push_result(ST_TICK_DONE, '0, 0, 1'b0, 1'b1);
      end
      MODE_REFRESH: begin
        if (hit < 0) begin
          push_result(ST_NOT_FOUND, k, 0, 1'b0, 1'b1);
        end else begin
          m_counter[hit] = COUNTER_W'(cv);
          m_online[hit]  = 1'b1;
          push_result(ST_OK, k, hit, 1'b1, 1'b1);
        end
      end
      MODE_ADD: begin
        if (hit >= 0) begin
          push_result(ST_PRESENT, k, hit, m_online[hit], 1'b1);
        end else begin
          for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!m_valid[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            push_result(ST_FULL, k, 0, 1'b0, 1'b1);
          end else begin
            m_valid[free_slot]    = 1'b1;
            m_key[free_slot]      = k;
            m_counter[free_slot]  = '0;
            m_interval[free_slot] = c_interval;
            m_online[free_slot]   = 1'b1;
            push_result(ST_OK, k, free_slot, 1'b1, 1'b1);
          end
        end
      end
      default: begin
        if (hit < 0) begin
          push_result(ST_NOT_FOUND, k, 0, 1'b0, 1'b1);
        end else begin
          m_valid[hit]  = 1'b0;
          m_online[hit] = 1'b0;
          push_result(ST_OK, k, hit, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    liveness_result_t want;
    if (rst) begin
      foreach (m_valid[i]) begin
        m_valid[i]    = 1'b0;
        m_key[i]      = '0;
        m_counter[i]  = '0;
        m_interval[i] = '0;
        m_online[i]   = 1'b0;
      end
      c_step     = RST_TICK_STEP;
      c_interval = RST_DEFAULT_INTERVAL;
      c_mult     = RST_TIMEOUT_MULTIPLE;
      awaited_results.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected result: status %0d key %h slot %0d online %b last %b",
                     $realtime, status, entry_key, entry_slot, now_online, last);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (status !== want.status || entry_key !== want.key || entry_slot !== want.slot ||
              now_online !== want.online || last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t exp/act st %0d/%0d key %h/%h slot %0d/%0d on %b/%b last %b/%b",
                       $realtime, want.status, status, want.key, entry_key, want.slot,
                       entry_slot, want.online, now_online, want.last, last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_STEP:        c_step     = cfg_data[STEP_W-1:0];
          CFG_DEFAULT_INTERVAL: c_interval = cfg_data[INTERVAL_W-1:0];
          CFG_TIMEOUT_MULTIPLE: c_mult     = cfg_data[MULT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_request(mode_t'(mode), device_key, counter_value);
    end
    pending = awaited_results.size();
  end

endmodule

### tb/heartbeat_liveness_table_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the heartbeat liveness table regression
module heartbeat_liveness_table_tb;
  import hlt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [MODE_W-1:0]     mode = '0;
  logic [KEY_W-1:0]      device_key = '0;
  logic [CVAL_W-1:0]     counter_value = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [STATUS_W-1:0]   status;
  logic [KEY_W-1:0]      entry_key;
  logic [SLOT_W-1:0]     entry_slot;
  logic                  now_online;
  logic                  last;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_off = 1'b0;
  logic [KEY_W-1:0] known_keys[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  heartbeat_liveness_table dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .device_key(device_key), .counter_value(counter_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .entry_key(entry_key), .entry_slot(entry_slot),
    .now_online(now_online), .last(last)
  );

  heartbeat_liveness_checker liveness_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .device_key(device_key), .counter_value(counter_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .entry_key(entry_key), .entry_slot(entry_slot),
    .now_online(now_online), .last(last),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  task automatic send_req(mode_t m, logic [KEY_W-1:0] k, logic [CVAL_W-1:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    device_key    <= k;
    counter_value <= cv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // drop valid and hold until every awaited result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(logic [STEP_W-1:0] step, logic [INTERVAL_W-1:0] intv,
                            logic [MULT_W-1:0] mult);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK_STEP;
    cfg_data  <= step;
    @(negedge clk);
    cfg_index <= CFG_DEFAULT_INTERVAL;
    cfg_data  <= intv;
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_MULTIPLE;
    cfg_data  <= {{(CFG_DATA_W-MULT_W){1'b0}}, mult};
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request();
    int r;
    int idx;
    logic [KEY_W-1:0] k;
    logic [CVAL_W-1:0] cv;
    r  = $urandom_range(99);
    k  = {$urandom, $urandom};
    cv = $urandom_range(127);
    idx = 0;
    if (known_keys.size() != 0 && r >= 45) begin
      idx = $urandom_range(known_keys.size() - 1);
    end
    if (r < 15) begin
      send_req(MODE_TICK, k, cv);
    end else if (r < 45) begin
      send_req(MODE_ADD, k, cv);
      known_keys.push_back(k);
    end else if (r < 52) begin
      if (known_keys.size() != 0) k = known_keys[idx];
      send_req(MODE_ADD, k, cv);
    end else if (r < 75) begin
      if (known_keys.size() != 0) k = known_keys[idx];
      send_req(MODE_REFRESH, k, cv);
    end else if (r < 80) begin
      send_req(MODE_REFRESH, k, cv);
    end else if (r < 92) begin
      if (known_keys.size() != 0) begin
        k = known_keys[idx];
        known_keys.delete(idx);
      end
      send_req(MODE_DELETE, k, cv);
    end else begin
      send_req(MODE_DELETE, k, cv);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_config(8'd100, 8'd1, 4'd15);
    send_req(MODE_ADD, '0, '0);
    send_req(MODE_ADD, '1, '1);
    send_req(MODE_ADD, '0, 7'd5);
    send_req(MODE_REFRESH, '0, 7'd127);
    send_req(MODE_REFRESH, 64'h0000_0000_0000_1234, 7'd3);
    send_req(MODE_DELETE, 64'hA5A5_A5A5_A5A5_A5A5, '0);
    send_req(MODE_TICK, '0, '0);
    send_req(MODE_ADD, '1, '0);
    send_req(MODE_TICK, '0, '0);
    send_req(MODE_REFRESH, '1, '0);
    send_req(MODE_DELETE, '0, '0);
    send_req(MODE_ADD, 64'h5555_5555_5555_5555, '0);
    send_req(MODE_TICK, '1, '1);
    send_req(MODE_DELETE, 64'h5555_5555_5555_5555, '1);
    send_req(MODE_DELETE, '1, '0);
    wait_idle();

    // zero registers: limit of zero, counters stand still
    set_config(8'd0, 8'd0, 4'd0);
    send_req(MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_req(MODE_TICK, '0, '0);
    send_req(MODE_REFRESH, 64'hAAAA_AAAA_AAAA_AAAA, 7'd1);
    send_req(MODE_TICK, '0, '0);
    send_req(MODE_REFRESH, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
    send_req(MODE_TICK, '0, '0);
    send_req(MODE_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          set_config(8'd5, 8'd30, 4'd3);
        end
        1: begin
          send_idle_pct = 73;
          stall_pct     = 0;
          set_config(8'd255, 8'd255, 4'd15);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 73;
          set_config(8'd1, 8'd1, 4'd1);
        end
        default: begin
          send_idle_pct = 9;
          stall_pct     = 9;
          set_config(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                     4'($urandom_range(15, 1)));
        end
      endcase
      if (p == 1) begin
        // fill the table past its end
        repeat (34) begin
          k = {$urandom, $urandom};
          send_req(MODE_ADD, k, 7'($urandom_range(127)));
          known_keys.push_back(k);
        end
      end
      if (p == 2) begin
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (26) random_request();
      wait_idle();
    end

    repeat (80) @(negedge clk);
    $display("Summary: %0d requests over six register settings and four idle mixes,",
             sent);
    $display("         %0d results compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
